// ----- src/itr_pkg.sv -----
// Shared constants, codes and types of the in-place matrix transpose block.
// No dependencies; every other file imports this package.
package itr_pkg;

	localparam int DEPTH      = 4096;
	localparam int DATA_WIDTH = 64;
	localparam int DIM_W      = 13;
	localparam int AW         = $clog2(DEPTH);
	localparam int CNT_W      = AW + 1;
	localparam int N_W        = 2 * DIM_W;
	// remainder of k / rows is below both rows and DEPTH
	localparam int R_W        = (AW < DIM_W) ? AW : DIM_W;
	localparam int P_W        = R_W + DIM_W;
	localparam int S_W        = ((P_W > AW) ? P_W : AW) + 1;
	localparam int DIV_CW     = $clog2(AW + 1);
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 1;

	localparam logic [MODE_W-1:0] MODE_LOAD      = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TRANSPOSE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ      = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b1;

	typedef struct packed {
		logic                  we;
		logic [AW-1:0]         waddr;
		logic [DATA_WIDTH-1:0] wdata;
		logic                  re;
		logic [AW-1:0]         raddr;
	} mem_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} eng_stat_t;

endpackage

// ----- src/itr_div.sv -----
// Restoring divider, one quotient bit per cycle: index / rows.
// Depends on itr_pkg.
module itr_div import itr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [AW-1:0]    dividend,
	input  logic [DIM_W-1:0] divisor,
	output logic             done,
	output logic [AW-1:0]    quot,
	output logic [R_W-1:0]   rem
);

	logic [DIV_CW-1:0] cnt_q;
	logic              done_q;
	logic [AW-1:0]     dvd_q;
	logic [DIM_W-1:0]  rem_q;
	logic [DIM_W:0]    partial;
	logic [DIM_W:0]    diff;
	logic              ge;

	assign partial = {rem_q, dvd_q[AW-1]};
	assign diff    = partial - {1'b0, divisor};
	assign ge      = partial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= DIV_CW'(AW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - DIV_CW'(1);
			done_q <= (cnt_q == DIV_CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// quotient bits shift in behind the dividend bits
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[AW-2:0], ge};
			rem_q <= ge ? diff[DIM_W-1:0] : partial[DIM_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = dvd_q;
	assign rem  = rem_q[R_W-1:0];

endmodule

// ----- src/itr_store.sv -----
// Matrix store: one write port and one read port with registered read data.
// Depends on itr_pkg.
module itr_store import itr_pkg::*; (
	input  logic                  clk,
	input  mem_req_t              req,
	output logic [DATA_WIDTH-1:0] rdata
);

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/itr_engine.sv -----
// Cycle-following transpose sequencer around one shared divider.
// Depends on itr_pkg and itr_div; drives the store through a mem_req_t.
module itr_engine import itr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [CNT_W-1:0]      n,
	input  logic [DIM_W-1:0]      rows,
	input  logic [DIM_W-1:0]      cols,
	input  logic [DATA_WIDTH-1:0] rdata,
	output eng_stat_t             stat,
	output mem_req_t              req
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_NEXT   = 4'd1;
	localparam logic [3:0] ST_LAUNCH = 4'd2;
	localparam logic [3:0] ST_DIV    = 4'd3;
	localparam logic [3:0] ST_SUM    = 4'd4;
	localparam logic [3:0] ST_WALK   = 4'd5;
	localparam logic [3:0] ST_HOLD   = 4'd6;
	localparam logic [3:0] ST_MOVE   = 4'd7;
	localparam logic [3:0] ST_FETCH  = 4'd8;

	logic [3:0]            state_q;
	logic [CNT_W-1:0]      n_q;
	logic [CNT_W-1:0]      start_q;
	logic                  first_q;
	logic                  moving_q;
	logic [AW-1:0]         cur_q;
	logic [AW-1:0]         src_q;
	logic [DATA_WIDTH-1:0] held_q;
	logic [P_W-1:0]        prod_s1;
	logic [AW-1:0]         quot_s1;

	logic                  div_done;
	logic [AW-1:0]         div_quot;
	logic [R_W-1:0]        div_rem;
	logic [S_W-1:0]        sum;
	logic [CNT_W-1:0]      src_ext;
	logic                  at_end;

	itr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_LAUNCH),
		.dividend (cur_q),
		.divisor  (rows),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// source index of cur: (cur mod rows) * cols + cur div rows
	assign sum     = S_W'(prod_s1) + S_W'(quot_s1);
	assign src_ext = CNT_W'(src_q);
	assign at_end  = (start_q == n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			n_q      <= '0;
			start_q  <= '0;
			first_q  <= 1'b0;
			moving_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						n_q     <= n;
						start_q <= '0;
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					if (at_end) begin
						state_q <= ST_IDLE;
					end else begin
						first_q  <= 1'b1;
						moving_q <= 1'b0;
						state_q  <= ST_LAUNCH;
					end
				end
				ST_LAUNCH: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: state_q <= moving_q ? ST_MOVE : ST_WALK;
				ST_WALK: begin
					if (src_ext > start_q) begin
						first_q <= 1'b0;
						state_q <= ST_LAUNCH;
					end else if (src_ext < start_q || first_q) begin
						// cycle led by a lower index, or a fixed point: skip
						start_q <= start_q + CNT_W'(1);
						state_q <= ST_NEXT;
					end else begin
						moving_q <= 1'b1;
						state_q  <= ST_HOLD;
					end
				end
				ST_HOLD: state_q <= ST_LAUNCH;
				ST_MOVE: begin
					if (src_ext == start_q) begin
						start_q <= start_q + CNT_W'(1);
						state_q <= ST_NEXT;
					end else begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: state_q <= ST_LAUNCH;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_NEXT: cur_q <= start_q[AW-1:0];
			ST_DIV: begin
				if (div_done) begin
					prod_s1 <= P_W'(div_rem) * P_W'(cols);
					quot_s1 <= div_quot;
				end
			end
			ST_SUM: src_q <= sum[AW-1:0];
			ST_WALK: begin
				if (src_ext > start_q) begin
					cur_q <= src_q;
				end else begin
					cur_q <= start_q[AW-1:0];
				end
			end
			ST_HOLD:  held_q <= rdata;
			ST_FETCH: cur_q  <= src_q;
			default: ;
		endcase
	end

	always_comb begin
		req       = '0;
		req.waddr = cur_q;
		req.raddr = src_q;
		unique case (state_q)
			ST_WALK: begin
				req.re    = !(src_ext > start_q) && !(src_ext < start_q) && !first_q;
				req.raddr = start_q[AW-1:0];
			end
			ST_MOVE: begin
				// close the cycle with the held word, else fetch the source
				req.we    = (src_ext == start_q);
				req.wdata = held_q;
				req.re    = (src_ext != start_q);
			end
			ST_FETCH: begin
				req.we    = 1'b1;
				req.wdata = rdata;
			end
			default: ;
		endcase
	end

	assign stat.busy = (state_q != ST_IDLE);
	assign stat.done = (state_q == ST_NEXT) && at_end;

endmodule

// ----- src/in_place_matrix_transpose_core.sv -----
// In-place matrix transpose: load, transpose by cycle following, read out.
// Depends on itr_pkg, itr_store and itr_engine.
//
// Words of a row-major num_rows x num_cols matrix are loaded one beat per
// cycle while in_stall is low (mode load); loads past rows*cols or past the
// store depth are dropped. A transpose beat permutes the store in place and
// returns one beat with last set; status is set and nothing moves when
// rows*cols exceeds the store depth. Read beats stream the transposed matrix
// from index zero and flag the final word; with one read in flight through
// the registered store output, the next input beat is stalled until that
// read returns. The transpose holds the input stalled while it walks each
// permutation cycle: every step of a walk or a move goes through one shared
// restoring divider. Register writes return both the load and read pointers
// to zero. The store needs no clearing after reset.
module in_place_matrix_transpose_core import itr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [DIM_W-1:0]      cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [MODE_W-1:0]     mode,
	input  logic [DATA_WIDTH-1:0] element,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [DATA_WIDTH-1:0] data,
	output logic                  last,
	output logic                  status
);

	logic [DIM_W-1:0]      cols_q;
	logic [DIM_W-1:0]      rows_q;
	logic [CNT_W-1:0]      load_ptr_q;
	logic [CNT_W-1:0]      read_ptr_q;
	logic                  pend_s1;
	logic                  last_s1;
	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic                  last_q;
	logic                  status_q;

	logic [N_W-1:0]        n_full;
	logic                  too_big;
	logic                  dim_bad;
	logic                  accept;
	logic                  load_ok;
	logic [CNT_W-1:0]      ptr_eff;
	logic                  rd_last;
	logic                  do_load;
	logic                  do_tp;
	logic                  do_rd;
	logic                  imm_result;
	logic                  rd_mem;
	logic [DATA_WIDTH-1:0] rdata;
	eng_stat_t             eng_stat;
	mem_req_t              eng_req;
	mem_req_t              front_req;
	mem_req_t              mem_req;

	assign n_full  = N_W'(cols_q) * N_W'(rows_q);
	assign too_big = n_full > N_W'(DEPTH);
	assign dim_bad = too_big || (n_full == '0);

	assign in_stall = eng_stat.busy || pend_s1 || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;

	assign load_ok = (N_W'(load_ptr_q) < n_full) && (load_ptr_q < CNT_W'(DEPTH));
	assign ptr_eff = (N_W'(read_ptr_q) >= n_full) ? '0 : read_ptr_q;
	assign rd_last = (N_W'(ptr_eff) == n_full - N_W'(1));

	always_comb begin
		do_load = 1'b0;
		do_tp   = 1'b0;
		do_rd   = 1'b0;
		if (accept) begin
			unique case (mode)
				MODE_LOAD:      do_load = 1'b1;
				MODE_TRANSPOSE: do_tp   = 1'b1;
				MODE_READ:      do_rd   = 1'b1;
				default: ;
			endcase
		end
	end

	assign imm_result = (do_tp || do_rd) && dim_bad;
	assign rd_mem     = do_rd && !dim_bad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q     <= DIM_W'(1);
			rows_q     <= DIM_W'(1);
			load_ptr_q <= '0;
			read_ptr_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_COLS: cols_q <= cfg_data;
				CFG_ROWS: rows_q <= cfg_data;
			endcase
			load_ptr_q <= '0;
			read_ptr_q <= '0;
		end else if (do_load && load_ok) begin
			load_ptr_q <= load_ptr_q + CNT_W'(1);
		end else if (do_tp || (do_rd && (dim_bad || rd_last))) begin
			load_ptr_q <= '0;
			read_ptr_q <= '0;
		end else if (rd_mem) begin
			read_ptr_q <= ptr_eff + CNT_W'(1);
		end
	end

	assign front_req.we    = do_load && load_ok;
	assign front_req.waddr = load_ptr_q[AW-1:0];
	assign front_req.wdata = element;
	assign front_req.re    = rd_mem;
	assign front_req.raddr = ptr_eff[AW-1:0];

	assign mem_req = eng_stat.busy ? eng_req : front_req;

	itr_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	itr_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (do_tp && !dim_bad),
		.n      (n_full[CNT_W-1:0]),
		.rows   (rows_q),
		.cols   (cols_q),
		.rdata  (rdata),
		.stat   (eng_stat),
		.req    (eng_req)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_s1 <= rd_mem;
			if (imm_result || pend_s1 || eng_stat.done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= rd_last;
		if (imm_result) begin
			data_q   <= '0;
			last_q   <= 1'b1;
			status_q <= too_big;
		end else if (pend_s1) begin
			data_q   <= rdata;
			last_q   <= last_s1;
			status_q <= 1'b0;
		end else if (eng_stat.done) begin
			data_q   <= '0;
			last_q   <= 1'b1;
			status_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign data      = data_q;
	assign last      = last_q;
	assign status    = status_q;

endmodule

// ----- src/itr_checker.sv -----
// Port-level checks of the transpose core, bound to the top level.
// Depends on itr_pkg and in_place_matrix_transpose_core.
module itr_checker import itr_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic [MODE_W-1:0]     mode,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [DATA_WIDTH-1:0] data,
	input logic                  last,
	input logic                  status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data) && $stable(last)
			&& $stable(status))
		else $error("stalled result beat changed");

	// a held result blocks new input beats
	a_back_pressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while result beat stalled");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && mode == MODE_LOAD && !out_valid |=> !out_valid)
		else $error("load beat produced a result");

	a_read_answer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && mode == MODE_READ && !out_valid |=> out_valid || in_stall)
		else $error("read beat neither answered nor pending");

endmodule

bind in_place_matrix_transpose_core itr_checker u_itr_checker (.*);

// ----- test/testbench.sv -----
// Self-checking testbench for in_place_matrix_transpose_core: a directed table, then random
// load/transpose/read phases checked against a shadow copy of the store.
// Depends on itr_pkg and the in_place_matrix_transpose_core RTL.
`timescale 1ns / 1ps

module testbench;
	import itr_pkg::*;

	localparam int LIMIT_NS = 200_000_000;
	localparam int RANDOM_BEATS = 1000;
	localparam int BIG_N = 960;
	localparam logic [DATA_WIDTH-1:0] ALL_ONES = '1;
	localparam logic [DATA_WIDTH-1:0] ODD_BITS = {(DATA_WIDTH/2){2'b01}};
	localparam logic [DATA_WIDTH-1:0] EVEN_BITS = {(DATA_WIDTH/2){2'b10}};
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] data;
		logic                  last;
		logic                  status;
	} beat_t;

	// one row of the directed table: a register write or an input beat
	typedef struct packed {
		bit                    is_reg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [DIM_W-1:0]      val;
		logic [MODE_W-1:0]     op;
		logic [DATA_WIDTH-1:0] word;
		bit                    known;
		beat_t                 want;
	} plan_row_t;

	typedef enum logic [1:0] {FLOW, SPOTTY, CHOPPY} stall_style_e;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [DIM_W-1:0]      cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [MODE_W-1:0]     mode;
	logic [DATA_WIDTH-1:0] element;
	logic                  out_valid;
	logic                  out_stall;
	logic [DATA_WIDTH-1:0] data;
	logic                  last;
	logic                  status;

	in_place_matrix_transpose_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.element   (element),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.data      (data),
		.last      (last),
		.status    (status)
	);

	// shadow of the block: store, pointers, dimensions
	logic [DATA_WIDTH-1:0] shadow [DEPTH];
	logic [DATA_WIDTH-1:0] scratch [DEPTH];
	int unsigned n_cols, n_rows, load_at, read_at, filled;

	beat_t        words_due [$];
	plan_row_t    plan [$];
	int           fails;
	int           taken;
	int           burst_left;
	stall_style_e stall_style;
	int           style_left;
	int unsigned  stall_tick;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#(LIMIT_NS);
		$display("in_place_matrix_transpose_core test failed");
		$finish;
	end

	// Apply one accepted beat to the shadow; return 1 when it yields a result beat.
	function automatic bit step_matrix(input logic [MODE_W-1:0] op,
			input logic [DATA_WIDTH-1:0] word, output beat_t r, output bit used);
		int unsigned n, k;
		bit too_big;
		n = n_rows * n_cols;
		too_big = n > DEPTH;
		r = '0;
		used = 1'b1;
		case (op)
		MODE_LOAD: begin
			if (load_at < n && load_at < DEPTH) begin
				shadow[AW'(load_at)] = word;
				load_at++;
				if (load_at > filled)
					filled = load_at;
			end else
				used = 1'b0;
			return 1'b0;
		end
		MODE_TRANSPOSE: begin
			if (!too_big && n > 0) begin
				for (k = 0; k < n; k++)
					scratch[AW'(k)] = shadow[AW'((k % n_rows) * n_cols + k / n_rows)];
				for (k = 0; k < n; k++)
					shadow[AW'(k)] = scratch[AW'(k)];
			end
			load_at = 0;
			read_at = 0;
			r.last = 1'b1;
			r.status = too_big;
			return 1'b1;
		end
		MODE_READ: begin
			if (too_big || n == 0) begin
				load_at = 0;
				read_at = 0;
				r.last = 1'b1;
				r.status = too_big;
				return 1'b1;
			end
			if (read_at >= n)
				read_at = 0;
			r.data = shadow[AW'(read_at)];
			if (read_at == n - 1) begin
				r.last = 1'b1;
				read_at = 0;
				load_at = 0;
			end else
				read_at++;
			return 1'b1;
		end
		default: begin
			used = 1'b0;
			return 1'b0;
		end
		endcase
	endfunction

	// reads and transposes may only touch entries that were loaded
	function automatic bit store_ready();
		int unsigned n;
		n = n_rows * n_cols;
		return n > DEPTH || n == 0 || filled >= n;
	endfunction

	function automatic logic [DATA_WIDTH-1:0] rand_word();
		case ($urandom_range(0, 15))
		0: return '0;
		1: return ALL_ONES;
		default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic plan_row_t cmd(input logic [MODE_W-1:0] op,
			input logic [DATA_WIDTH-1:0] word);
		plan_row_t s;
		s = '0;
		s.op = op;
		s.word = word;
		return s;
	endfunction

	function automatic plan_row_t cmd_known(input logic [MODE_W-1:0] op,
			input logic [DATA_WIDTH-1:0] d, input logic l, input logic st);
		plan_row_t s;
		s = cmd(op, '0);
		s.known = 1'b1;
		s.want.data = d;
		s.want.last = l;
		s.want.status = st;
		return s;
	endfunction

	function automatic plan_row_t reg_wr(input logic [CFG_IDX_W-1:0] idx,
			input logic [DIM_W-1:0] val);
		plan_row_t s;
		s = '0;
		s.is_reg = 1'b1;
		s.idx = idx;
		s.val = val;
		return s;
	endfunction

	task automatic flag(input string what, input logic [DATA_WIDTH-1:0] want,
			input logic [DATA_WIDTH-1:0] got);
		fails++;
		if (fails <= 10)
			$display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
	endtask

	task automatic check_beat();
		beat_t want;
		if (words_due.size() == 0) begin
			flag("unexpected result beat", '0, data);
			return;
		end
		want = words_due.pop_front();
		if (data !== want.data)
			flag("data", want.data, data);
		if (last !== want.last)
			flag("last", DATA_WIDTH'(want.last), DATA_WIDTH'(last));
		if (status !== want.status)
			flag("status", DATA_WIDTH'(want.status), DATA_WIDTH'(status));
	endtask

	// hold the beat until taken, then record what it should produce
	task automatic push_beat(input logic [MODE_W-1:0] op, input logic [DATA_WIDTH-1:0] word,
			input bit known, input beat_t want);
		beat_t r;
		bit has, used;
		in_valid <= 1'b1;
		mode <= op;
		element <= word;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		has = step_matrix(op, word, r, used);
		if (has)
			words_due.push_back(known ? want : r);
		if (used)
			taken++;
	endtask

	// end the current burst with a gap of random length now and then
	task automatic pace();
		if (burst_left > 0)
			burst_left--;
		else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 20 : 4))
				@(posedge clk);
			burst_left = $urandom_range(0, ($urandom_range(0, 3) == 0) ? 60 : 12);
		end
	endtask

	task automatic drive(input logic [MODE_W-1:0] op, input logic [DATA_WIDTH-1:0] word);
		push_beat(op, word, 1'b0, '0);
		pace();
	endtask

	// drain every pending result, then let a trailing load finish
	task automatic settle();
		in_valid <= 1'b0;
		while (words_due.size() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_COLS)
			n_cols = 32'(val);
		else
			n_rows = 32'(val);
		load_at = 0;
		read_at = 0;
	endtask

	task automatic set_dims(input logic [DIM_W-1:0] cols, input logic [DIM_W-1:0] rows);
		if ($urandom_range(0, 1)) begin
			write_reg(CFG_COLS, cols);
			write_reg(CFG_ROWS, rows);
		end else begin
			write_reg(CFG_ROWS, rows);
			write_reg(CFG_COLS, cols);
		end
	endtask

	task automatic stray_beat();
		logic [MODE_W-1:0] op;
		op = MODE_W'($urandom_range(0, 3));
		if ((op == MODE_READ || op == MODE_TRANSPOSE) && !store_ready())
			op = MODE_LOAD;
		drive(op, rand_word());
	endtask

	task automatic maybe_stray();
		if ($urandom_range(0, 19) == 0)
			stray_beat();
	endtask

	// one matrix: new dimensions, load, transpose, read back, with some noise mixed in
	task automatic run_phase();
		int unsigned pick, n, loads, reads;
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			case ($urandom_range(0, 2))
			0: set_dims('1, '1);
			1: set_dims(DIM_W'(DEPTH), DIM_W'(2));
			default: set_dims(DIM_W'(65), DIM_W'(64));
			endcase
		end else if (pick < 9) begin
			if ($urandom_range(0, 1))
				set_dims(DIM_W'(0), DIM_W'($urandom_range(0, 8191)));
			else
				set_dims(DIM_W'($urandom_range(0, 8191)), DIM_W'(0));
		end else if (pick < 15)
			set_dims(DIM_W'($urandom_range(1, 12)), DIM_W'($urandom_range(1, 12)));
		else
			set_dims(DIM_W'($urandom_range(1, 6)), DIM_W'($urandom_range(1, 6)));
		n = n_rows * n_cols;
		if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(4, 30))
				stray_beat();
			return;
		end
		loads = (n > DEPTH) ? $urandom_range(0, 6) : n;
		if ($urandom_range(0, 3) == 0)
			loads += $urandom_range(1, 3);
		repeat (loads) begin
			maybe_stray();
			drive(MODE_LOAD, rand_word());
		end
		if ($urandom_range(0, 9) != 0)
			drive(MODE_TRANSPOSE, rand_word());
		if (n > DEPTH || n == 0)
			reads = $urandom_range(1, 3);
		else if ($urandom_range(0, 4) == 0)
			reads = $urandom_range(1, n);
		else
			reads = n * $urandom_range(1, 2);
		repeat (reads) begin
			maybe_stray();
			drive(MODE_READ, rand_word());
		end
		if ($urandom_range(0, 7) == 0)
			settle();
	endtask

	// receiver: check accepted beats, then pick the next stall value
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				check_beat();
			if (style_left == 0) begin
				stall_style = stall_style_e'($urandom_range(0, 2));
				style_left = $urandom_range(32, 400);
			end else
				style_left--;
			stall_tick++;
			case (stall_style)
			FLOW: out_stall <= 1'b0;
			SPOTTY: out_stall <= ($urandom_range(0, 2) == 0);
			default: out_stall <= (stall_tick % 9) < 4;
			endcase
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_COLS;
		cfg_data = '0;
		in_valid = 1'b0;
		mode = MODE_LOAD;
		element = '0;
		out_stall = 1'b0;
		fails = 0;
		taken = 0;
		burst_left = 0;
		stall_style = FLOW;
		style_left = 0;
		stall_tick = 0;
		n_cols = 1;
		n_rows = 1;
		load_at = 0;
		read_at = 0;
		filled = 0;

		// 1x1 after reset, unused mode, empty matrix, oversized matrix, then a 2x2
		plan.push_back(cmd(MODE_LOAD, ALL_ONES));
		plan.push_back(cmd_known(MODE_READ, ALL_ONES, 1'b1, 1'b0));
		plan.push_back(cmd(MODE_UNUSED, ALL_ONES));
		plan.push_back(cmd_known(MODE_TRANSPOSE, '0, 1'b1, 1'b0));
		plan.push_back(reg_wr(CFG_COLS, DIM_W'(0)));
		plan.push_back(cmd_known(MODE_READ, '0, 1'b1, 1'b0));
		plan.push_back(cmd_known(MODE_TRANSPOSE, '0, 1'b1, 1'b0));
		plan.push_back(reg_wr(CFG_COLS, '1));
		plan.push_back(reg_wr(CFG_ROWS, DIM_W'(DEPTH)));
		plan.push_back(cmd_known(MODE_READ, '0, 1'b1, 1'b1));
		plan.push_back(cmd_known(MODE_TRANSPOSE, '0, 1'b1, 1'b1));
		plan.push_back(reg_wr(CFG_COLS, DIM_W'(2)));
		plan.push_back(reg_wr(CFG_ROWS, DIM_W'(2)));
		plan.push_back(cmd(MODE_LOAD, ODD_BITS));
		plan.push_back(cmd(MODE_LOAD, EVEN_BITS));
		plan.push_back(cmd(MODE_LOAD, '0));
		plan.push_back(cmd(MODE_LOAD, ALL_ONES));
		plan.push_back(cmd(MODE_LOAD, ODD_BITS));
		plan.push_back(cmd_known(MODE_TRANSPOSE, '0, 1'b1, 1'b0));
		repeat (5)
			plan.push_back(cmd(MODE_READ, ALL_ONES));

		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_reg)
				write_reg(plan[i].idx, plan[i].val);
			else begin
				push_beat(plan[i].op, plan[i].word, plan[i].known, plan[i].want);
				pace();
			end
		end

		// a large matrix in three shapes; the sender waits out all results first
		set_dims(DIM_W'(1), DIM_W'(BIG_N));
		repeat (BIG_N)
			drive(MODE_LOAD, rand_word());
		drive(MODE_LOAD, rand_word());
		settle();
		drive(MODE_TRANSPOSE, '0);
		repeat (20)
			drive(MODE_READ, '0);
		set_dims(DIM_W'(32), DIM_W'(30));
		drive(MODE_TRANSPOSE, rand_word());
		repeat (70)
			drive(MODE_READ, rand_word());
		set_dims(DIM_W'(BIG_N), DIM_W'(1));
		drive(MODE_TRANSPOSE, '0);
		repeat (10)
			drive(MODE_READ, '0);

		taken = 0;
		while (taken < RANDOM_BEATS)
			run_phase();

		settle();
		repeat (12)
			@(posedge clk);
		if (fails == 0)
			$display("in_place_matrix_transpose_core test passed");
		else
			$display("in_place_matrix_transpose_core test failed");
		$finish;
	end

endmodule
